FILE: sv/mrpd_pkg.sv
// Package for the monitor response packet decoder.
// Holds result record type, code constants and the saturating count helper.
// No dependencies.
package mrpd_pkg;

  // Default for the decoded packet length limit
  localparam int PACKET_BYTES_DEF = 256;

  // Packet geometry
  localparam logic [15:0] POS_ADDRESS   = 16'd0;
  localparam logic [15:0] POS_STATUS    = 16'd4;
  localparam logic [15:0] POS_COUNT     = 16'd5;
  localparam logic [15:0] POS_SIZE_LO   = 16'd6;
  localparam logic [15:0] POS_SIZE_HI   = 16'd7;
  localparam logic [15:0] POS_MODE      = 16'd10;
  localparam logic [15:0] POS_FACTOR    = 16'd11;
  localparam logic [15:0] POS_SATURATED = 16'hFFFF;
  localparam logic [15:0] IDLE_SIZE     = 16'd4;
  localparam logic [3:0]  SCAN_OVERHEAD = 4'd13;
  localparam logic [3:0]  MEAN_OVERHEAD = 4'd14;
  localparam logic [7:0]  MASK_BYTES    = 8'd8;
  localparam logic [16:0] SECOND_BASE   = 17'd6;

  // Result kinds
  localparam logic [1:0] KIND_MASK    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [1:0] KIND_ARG     = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // Status codes
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_OTHER     = 3'd6;

  // Raw status byte values
  localparam logic [7:0] RAW_UNKNOWN   = 8'd4;
  localparam logic [7:0] RAW_TOO_LARGE = 8'd8;
  localparam logic [7:0] RAW_TRUNCATED = 8'd16;

  // Modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SCAN   = 2'd1;
  localparam logic [1:0] MODE_MEAN   = 2'd2;
  localparam logic [1:0] MODE_LIMITS = 2'd3;

  // First packet layout
  localparam logic [1:0] LAY_NONE   = 2'd0;
  localparam logic [1:0] LAY_MASK11 = 2'd1;
  localparam logic [1:0] LAY_MASK12 = 2'd2;

  // Second packet offsets
  localparam logic [15:0] OFF_SIZE_LO = 16'd0;
  localparam logic [15:0] OFF_SIZE_HI = 16'd1;
  localparam logic [15:0] OFF_TYPE    = 16'd2;
  localparam logic [15:0] OFF_SUBTYPE = 16'd3;
  localparam logic [15:0] OFF_ARG0    = 16'd4;

  // Second packet types
  localparam logic [7:0] TYPE_CTRL    = 8'd1;
  localparam logic [7:0] TYPE_QUERY   = 8'd2;
  localparam logic [7:0] TYPE_RESET   = 8'd3;
  localparam logic [7:0] TYPE_RELOAD  = 8'd5;
  localparam logic [7:0] TYPE_ECHO    = 8'd6;
  localparam logic [7:0] TYPE_BOX     = 8'd7;

  // Command numbers
  localparam logic [4:0] CMD_NULL       = 5'd1;
  localparam logic [4:0] CMD_CTRL0_BASE = 5'd2;
  localparam logic [4:0] CMD_CTRL_BASE  = 5'd4;
  localparam logic [4:0] CMD_QUERY_S0   = 5'd9;
  localparam logic [4:0] CMD_QUERY_S1   = 5'd10;
  localparam logic [4:0] CMD_QUERY_S2   = 5'd11;
  localparam logic [4:0] CMD_QUERY_S5   = 5'd12;
  localparam logic [4:0] CMD_QUERY_S3   = 5'd13;
  localparam logic [4:0] CMD_QUERY_S4   = 5'd14;
  localparam logic [4:0] CMD_RELOAD     = 5'd15;
  localparam logic [4:0] CMD_RESET      = 5'd16;
  localparam logic [4:0] CMD_ECHO       = 5'd17;
  localparam logic [4:0] CMD_BOX_MON    = 5'd18;
  localparam logic [4:0] CMD_BOX_LIST   = 5'd19;

  // One result record
  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] item_index;
    logic [7:0] item_value;
    logic [7:0] unit_address;
    logic [2:0] status_code;
    logic [1:0] mode;
    logic [7:0] average_factor;
    logic [4:0] command_number;
    logic [7:0] box_number;
    logic [7:0] version_code;
    logic [7:0] channel_count;
    logic       last_result;
  } res_t;

  // Results produced by one byte
  typedef struct packed {
    logic item_vld;
    logic sum_vld;
  } push_t;

  // x - k clamped to 0..255
  function automatic logic [7:0] sat_sub(input logic [15:0] x, input logic [3:0] k);
    logic [15:0] d;
    d = x - {12'd0, k};
    if (x <= {12'd0, k}) return 8'd0;
    else if (d > 16'd255) return 8'hFF;
    else return d[7:0];
  endfunction

endpackage

FILE: sv/mrpd_decode.sv
// Byte decoder: packet position tracking, field capture and result records.
// Depends on mrpd_pkg.
module mrpd_decode #(
  parameter int PACKET_BYTES = mrpd_pkg::PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output mrpd_pkg::push_t  push,
  output mrpd_pkg::res_t   item_rec,
  output mrpd_pkg::res_t   sum_rec
);

  localparam logic [16:0] LIMIT = 17'(PACKET_BYTES);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] fsz_r, fsz_nxt;
  logic [15:0] ssz_r, ssz_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic        single_r, single_nxt;
  logic [1:0]  lay_r, lay_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [4:0]  cmd_r, cmd_nxt;
  logic [7:0]  factor_r, factor_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  box_r, box_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [2:0]  status_r, status_nxt;

  logic        decode_en;
  logic [16:0] start;
  logic [15:0] off;
  logic [15:0] a_start;
  logic [15:0] a_end;
  logic [7:0]  base;
  logic        hit;
  logic [1:0]  kind;
  logic [7:0]  idx;

  // Field capture and run detection for the current byte
  always_comb begin
    pos_nxt     = pos_r;
    fsz_nxt     = fsz_r;
    ssz_nxt     = ssz_r;
    type_nxt    = type_r;
    sub_nxt     = sub_r;
    single_nxt  = single_r;
    lay_nxt     = lay_r;
    mode_nxt    = mode_r;
    cmd_nxt     = cmd_r;
    factor_nxt  = factor_r;
    version_nxt = version_r;
    box_nxt     = box_r;
    count_nxt   = count_r;
    addr_nxt    = addr_r;
    status_nxt  = status_r;
    hit         = 1'b0;
    kind        = mrpd_pkg::KIND_MASK;
    idx         = 8'd0;
    a_start     = mrpd_pkg::OFF_ARG0;
    a_end       = mrpd_pkg::OFF_ARG0;
    base        = (lay_r == mrpd_pkg::LAY_MASK12) ? 8'd12 : 8'd11;

    decode_en = ({1'b0, pos_r} < LIMIT) && (pos_r != mrpd_pkg::POS_SATURATED);
    start     = mrpd_pkg::SECOND_BASE + {1'b0, fsz_r};
    off       = pos_r - start[15:0];

    if (decode_en) begin
      if (pos_r == mrpd_pkg::POS_ADDRESS) begin
        addr_nxt = data_byte;
      end else if (pos_r == mrpd_pkg::POS_STATUS) begin
        if (data_byte <= 8'd2) status_nxt = data_byte[2:0];
        else if (data_byte == mrpd_pkg::RAW_UNKNOWN) status_nxt = mrpd_pkg::ST_UNKNOWN;
        else if (data_byte == mrpd_pkg::RAW_TOO_LARGE) status_nxt = mrpd_pkg::ST_TOO_LARGE;
        else if (data_byte == mrpd_pkg::RAW_TRUNCATED) status_nxt = mrpd_pkg::ST_TRUNCATED;
        else status_nxt = mrpd_pkg::ST_OTHER;
      end else if (pos_r == mrpd_pkg::POS_COUNT) begin
        single_nxt = (data_byte == 8'd1);
        if (data_byte == 8'd1) cmd_nxt = mrpd_pkg::CMD_NULL;
      end else if (pos_r == mrpd_pkg::POS_SIZE_LO) begin
        fsz_nxt = {8'd0, data_byte};
      end else if (pos_r == mrpd_pkg::POS_SIZE_HI) begin
        fsz_nxt = {data_byte, fsz_r[7:0]};
        if (fsz_nxt == mrpd_pkg::IDLE_SIZE) mode_nxt = mrpd_pkg::MODE_IDLE;
        // second packet starting on the size bytes themselves
        if (!single_r && fsz_nxt == 16'd0) ssz_nxt = fsz_nxt;
        else if (!single_r && fsz_nxt == 16'd1) ssz_nxt = {8'd0, data_byte};
      end else if (!single_r && {1'b0, pos_r} >= start) begin
        // second packet
        if (off == mrpd_pkg::OFF_SIZE_LO) begin
          ssz_nxt = {ssz_r[15:8], data_byte};
        end else if (off == mrpd_pkg::OFF_SIZE_HI) begin
          ssz_nxt = {data_byte, ssz_r[7:0]};
        end else if (off == mrpd_pkg::OFF_TYPE) begin
          type_nxt = data_byte;
          if (data_byte == mrpd_pkg::TYPE_RESET) cmd_nxt = mrpd_pkg::CMD_RESET;
          else if (data_byte == mrpd_pkg::TYPE_RELOAD) cmd_nxt = mrpd_pkg::CMD_RELOAD;
          else if (data_byte == mrpd_pkg::TYPE_ECHO) cmd_nxt = mrpd_pkg::CMD_ECHO;
        end else if (off == mrpd_pkg::OFF_SUBTYPE) begin
          sub_nxt = data_byte;
          if (type_r == mrpd_pkg::TYPE_CTRL) begin
            if (data_byte >= 8'd1 && data_byte <= 8'd4)
              cmd_nxt = mrpd_pkg::CMD_CTRL_BASE + data_byte[4:0];
          end else if (type_r == mrpd_pkg::TYPE_QUERY) begin
            case (data_byte)
              8'd0:    cmd_nxt = mrpd_pkg::CMD_QUERY_S0;
              8'd1:    cmd_nxt = mrpd_pkg::CMD_QUERY_S1;
              8'd2:    cmd_nxt = mrpd_pkg::CMD_QUERY_S2;
              8'd3:    cmd_nxt = mrpd_pkg::CMD_QUERY_S3;
              8'd4:    cmd_nxt = mrpd_pkg::CMD_QUERY_S4;
              8'd5:    cmd_nxt = mrpd_pkg::CMD_QUERY_S5;
              default: cmd_nxt = cmd_r;
            endcase
          end else if (type_r == mrpd_pkg::TYPE_BOX) begin
            if (data_byte != 8'd0) begin
              cmd_nxt   = mrpd_pkg::CMD_BOX_LIST;
              count_nxt = mrpd_pkg::sat_sub(ssz_r, 4'd4);
            end else begin
              cmd_nxt   = mrpd_pkg::CMD_BOX_MON;
              count_nxt = mrpd_pkg::sat_sub(ssz_r, 4'd5);
            end
          end
        end else if (off == mrpd_pkg::OFF_ARG0) begin
          if (type_r == mrpd_pkg::TYPE_CTRL && sub_r == 8'd0) begin
            if (data_byte <= 8'd2) cmd_nxt = mrpd_pkg::CMD_CTRL0_BASE + data_byte[4:0];
          end else if (type_r == mrpd_pkg::TYPE_QUERY && sub_r == 8'd3) begin
            version_nxt = data_byte;
          end else if (type_r == mrpd_pkg::TYPE_QUERY && sub_r == 8'd4) begin
            mode_nxt = (data_byte <= 8'd2) ? data_byte[1:0] : mrpd_pkg::MODE_LIMITS;
          end else if (type_r == mrpd_pkg::TYPE_BOX && sub_r == 8'd0) begin
            box_nxt = data_byte;
          end
        end

        // argument run: start offset and exclusive end
        if (type_nxt == mrpd_pkg::TYPE_CTRL) begin
          if (sub_nxt == 8'd1 || sub_nxt == 8'd4) a_end = 16'd12;
          else if (sub_nxt == 8'd2) a_end = 16'd6;
          else if (sub_nxt == 8'd3) a_end = 16'd8;
        end else if (type_nxt == mrpd_pkg::TYPE_QUERY) begin
          if (sub_nxt == 8'd0 || sub_nxt == 8'd5) a_end = 16'd12;
          else if (sub_nxt == 8'd1) a_end = 16'd6;
          else if (sub_nxt == 8'd2) a_end = 16'd8;
        end else if (type_nxt == mrpd_pkg::TYPE_RESET || type_nxt == mrpd_pkg::TYPE_ECHO) begin
          a_start = mrpd_pkg::OFF_SUBTYPE;
          a_end   = 16'd5;
        end else if (type_nxt == mrpd_pkg::TYPE_BOX) begin
          a_start = (sub_nxt != 8'd0) ? 16'd4 : 16'd5;
          a_end   = ssz_nxt;
        end
        if (off >= mrpd_pkg::OFF_SUBTYPE && off >= a_start && off < a_end) begin
          hit  = 1'b1;
          kind = mrpd_pkg::KIND_ARG;
          idx  = off[7:0] - a_start[7:0];
        end
      end else if (pos_r == mrpd_pkg::POS_MODE && fsz_r != mrpd_pkg::IDLE_SIZE) begin
        // mode byte of the first packet
        if (data_byte == 8'd1 || data_byte == 8'd3) begin
          mode_nxt  = data_byte[1:0];
          lay_nxt   = mrpd_pkg::LAY_MASK11;
          count_nxt = mrpd_pkg::sat_sub(fsz_r, mrpd_pkg::SCAN_OVERHEAD);
        end else if (data_byte == 8'd2) begin
          mode_nxt  = mrpd_pkg::MODE_MEAN;
          lay_nxt   = mrpd_pkg::LAY_MASK12;
          count_nxt = mrpd_pkg::sat_sub(fsz_r, mrpd_pkg::MEAN_OVERHEAD);
        end
      end else begin
        // mask and samples of the first packet
        if (pos_r == mrpd_pkg::POS_FACTOR && lay_r == mrpd_pkg::LAY_MASK12)
          factor_nxt = data_byte;
        if (lay_r != mrpd_pkg::LAY_NONE && pos_r >= {8'd0, base}) begin
          if (pos_r < {8'd0, base} + {8'd0, mrpd_pkg::MASK_BYTES}) begin
            hit  = 1'b1;
            kind = mrpd_pkg::KIND_MASK;
            idx  = pos_r[7:0] - base;
          end else if ({1'b0, pos_r} < start) begin
            hit  = 1'b1;
            kind = mrpd_pkg::KIND_SAMPLE;
            idx  = pos_r[7:0] - base - mrpd_pkg::MASK_BYTES;
          end
        end
      end
    end

    // position advance, end of packet clears the framing state
    if (pos_r != mrpd_pkg::POS_SATURATED) pos_nxt = pos_r + 16'd1;
    if (last_byte) begin
      pos_nxt    = 16'd0;
      fsz_nxt    = 16'd0;
      ssz_nxt    = 16'd0;
      type_nxt   = 8'd0;
      sub_nxt    = 8'd0;
      single_nxt = 1'b0;
      lay_nxt    = mrpd_pkg::LAY_NONE;
    end
  end

  // Result records carry the registers after this byte
  always_comb begin
    item_rec.item_kind      = kind;
    item_rec.item_index     = idx;
    item_rec.item_value     = data_byte;
    item_rec.unit_address   = addr_nxt;
    item_rec.status_code    = status_nxt;
    item_rec.mode           = mode_nxt;
    item_rec.average_factor = factor_nxt;
    item_rec.command_number = cmd_nxt;
    item_rec.box_number     = box_nxt;
    item_rec.version_code   = version_nxt;
    item_rec.channel_count  = count_nxt;
    item_rec.last_result    = 1'b0;
    sum_rec                 = item_rec;
    sum_rec.item_kind       = mrpd_pkg::KIND_SUMMARY;
    sum_rec.item_index      = 8'd0;
    sum_rec.item_value      = 8'd0;
    sum_rec.last_result     = 1'b1;
    push.item_vld           = step && hit;
    push.sum_vld            = step && last_byte;
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd0;
      fsz_r     <= 16'd0;
      ssz_r     <= 16'd0;
      type_r    <= 8'd0;
      sub_r     <= 8'd0;
      single_r  <= 1'b0;
      lay_r     <= mrpd_pkg::LAY_NONE;
      mode_r    <= mrpd_pkg::MODE_IDLE;
      cmd_r     <= mrpd_pkg::CMD_NULL;
      factor_r  <= 8'd0;
      version_r <= 8'd0;
      box_r     <= 8'd0;
      count_r   <= 8'd0;
      addr_r    <= 8'd0;
      status_r  <= mrpd_pkg::ST_OTHER;
    end else if (step) begin
      pos_r     <= pos_nxt;
      fsz_r     <= fsz_nxt;
      ssz_r     <= ssz_nxt;
      type_r    <= type_nxt;
      sub_r     <= sub_nxt;
      single_r  <= single_nxt;
      lay_r     <= lay_nxt;
      mode_r    <= mode_nxt;
      cmd_r     <= cmd_nxt;
      factor_r  <= factor_nxt;
      version_r <= version_nxt;
      box_r     <= box_nxt;
      count_r   <= count_nxt;
      addr_r    <= addr_nxt;
      status_r  <= status_nxt;
    end
  end

endmodule

FILE: sv/mrpd_outq.sv
// Result queue: four records, up to two written and one read per cycle.
// Depends on mrpd_pkg.
module mrpd_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  mrpd_pkg::push_t  push,
  input  mrpd_pkg::res_t   item_rec,
  input  mrpd_pkg::res_t   sum_rec,
  input  logic             pop,
  output logic             rd_vld,
  output mrpd_pkg::res_t   rd_rec,
  output logic [2:0]       fill
);

  mrpd_pkg::res_t mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_push;
  logic       do_pop;

  // Pointer and fill bookkeeping
  always_comb begin
    n_push  = {1'b0, push.item_vld} + {1'b0, push.sum_vld};
    do_pop  = pop && (cnt_r != 3'd0);
    wr_nxt  = wr_r + n_push;
    rd_nxt  = rd_r + {1'b0, do_pop};
    cnt_nxt = cnt_r + {1'b0, n_push} - {2'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage: item record first, summary after it
  always_ff @(posedge clk) begin
    if (push.item_vld) mem_r[wr_r] <= item_rec;
    else if (push.sum_vld) mem_r[wr_r] <= sum_rec;
    if (push.item_vld && push.sum_vld) mem_r[wr_r + 2'd1] <= sum_rec;
  end

  assign rd_vld = (cnt_r != 3'd0);
  assign rd_rec = mem_r[rd_r];
  assign fill   = cnt_r;

endmodule

FILE: sv/monitor_response_packet_decoder.sv
// Monitor response packet decoder, top level.
// Input register, byte decoder and result queue; depends on mrpd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one packet byte per
//   transaction, in_last_byte marking the final byte of a packet.
//   Result channel (out_valid/out_ready) carries tagged mask, sample and
//   argument bytes, and one summary record after the last byte.
//   Throughput: one byte per cycle while the result queue has room for
//   two records. A byte yields zero, one or two results. A result passes
//   through the input register and then the result queue before it is
//   offered on the output.
//   The four-entry result queue lets input continue while the receiver
//   stalls; in_ready drops once the input register is full and the queue holds more than two records.
//   Reset (rst_n low, synchronous) clears the packet position, empties
//   the queue and returns the decoded registers to idle mode, the null
//   command and status "other".
module monitor_response_packet_decoder #(
  parameter int PACKET_BYTES = mrpd_pkg::PACKET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_item_index,
  output logic [7:0] out_item_value,
  output logic [7:0] out_unit_address,
  output logic [2:0] out_status_code,
  output logic [1:0] out_mode,
  output logic [7:0] out_average_factor,
  output logic [4:0] out_command_number,
  output logic [7:0] out_box_number,
  output logic [7:0] out_version_code,
  output logic [7:0] out_channel_count,
  output logic       out_last_result
);

  logic       vld_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       step;
  logic [2:0] fill;

  mrpd_pkg::push_t push;
  mrpd_pkg::res_t  item_rec;
  mrpd_pkg::res_t  sum_rec;
  mrpd_pkg::res_t  rd_rec;

  // Input register advances when the queue has room for two records
  assign step     = vld_r && (fill <= 3'd2);
  assign in_ready = !vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  mrpd_decode #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (data_r),
    .last_byte (last_r),
    .push      (push),
    .item_rec  (item_rec),
    .sum_rec   (sum_rec)
  );

  mrpd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_rec (item_rec),
    .sum_rec  (sum_rec),
    .pop      (out_ready),
    .rd_vld   (out_valid),
    .rd_rec   (rd_rec),
    .fill     (fill)
  );

  // Result fields
  assign out_item_kind      = rd_rec.item_kind;
  assign out_item_index     = rd_rec.item_index;
  assign out_item_value     = rd_rec.item_value;
  assign out_unit_address   = rd_rec.unit_address;
  assign out_status_code    = rd_rec.status_code;
  assign out_mode           = rd_rec.mode;
  assign out_average_factor = rd_rec.average_factor;
  assign out_command_number = rd_rec.command_number;
  assign out_box_number     = rd_rec.box_number;
  assign out_version_code   = rd_rec.version_code;
  assign out_channel_count  = rd_rec.channel_count;
  assign out_last_result    = rd_rec.last_result;

`ifndef SYNTHESIS
  // queue never overflows
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= 3'd4)
    else $error("result queue overflow");

  // a byte only enters when the previous one moves on
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!vld_r || step))
    else $error("input register overwritten");

  // summary records are tagged and carry no byte
  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |->
      (out_item_kind == mrpd_pkg::KIND_SUMMARY && out_item_index == 8'd0 &&
       out_item_value == 8'd0))
    else $error("malformed summary record");

  // a processed last byte always queues a summary
  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_r) |=> out_valid)
    else $error("summary missing after last byte");
`endif

endmodule
